// ===== rtl/skl_pkg.sv =====
package skl_pkg;

    localparam int KEY_W = 32;
    localparam int FIELD_W = 7;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

    typedef struct packed {
        logic                    req_type;
        logic signed [KEY_W-1:0] req_key;
    } skl_req_t;

    typedef struct packed {
        logic               key_found;
        logic [FIELD_W-1:0] rank_less;
        logic [FIELD_W-1:0] first_match_index;
        logic [FIELD_W-1:0] entry_count;
        logic               insert_refused;
    } skl_rsp_t;

endpackage

// ===== rtl/sorted_key_list.sv =====
// Sorted key list: keeps up to CAPACITY signed 32-bit keys in ascending order in
// a single-port-read, single-port-write RAM and answers one request per beat.
// One request is worked on at a time; s_ready is high only while the engine is
// free, and a finished result waits in an output register so the next request
// can start before m_ready returns. A lookup, or an insert into a full list,
// scans upward from entry 0 one RAM read per cycle until it meets a key not
// below the request key. An insert scans downward from the last entry, moving
// each key not below the request key up by one place as it goes.
module sorted_key_list
    import skl_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  skl_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output skl_rsp_t m_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic             engine_idle;
    logic             res_valid;
    logic             res_ready;
    skl_rsp_t         res;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [KEY_W-1:0] rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic             m_valid_reg;
    skl_rsp_t         m_data_reg;

    assign s_ready = engine_idle;

    skl_engine #(
        .CAPACITY(CAPACITY),
        .AW(AW),
        .CW(CW)
    ) u_engine (
        .aclk(aclk),
        .aresetn(aresetn),
        .start(s_valid && engine_idle),
        .req(s_data),
        .idle(engine_idle),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    skl_key_ram #(
        .DEPTH(CAPACITY),
        .AW(AW)
    ) u_ram (
        .aclk(aclk),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/skl_key_ram.sv =====
module skl_key_ram
    import skl_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW = 6
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [KEY_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [KEY_W-1:0] wr_data
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/skl_engine.sv =====
module skl_engine
    import skl_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  skl_req_t         req,
    output logic             idle,
    output logic             res_valid,
    input  logic             res_ready,
    output skl_rsp_t         res,
    output logic             rd_en,
    output logic [AW-1:0]    rd_addr,
    input  logic [KEY_W-1:0] rd_data,
    output logic             wr_en,
    output logic [AW-1:0]    wr_addr,
    output logic [KEY_W-1:0] wr_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UP   = 3'd1;
    localparam logic [2:0] ST_DOWN = 3'd2;
    localparam logic [2:0] ST_PUT  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CW-1:0]    rank_reg, rank_next;
    logic [CW-1:0]    first_reg, first_next;
    logic             found_reg, found_next;
    logic             refused_reg, refused_next;
    logic [CW-1:0]    idx_inc;
    logic [CW-1:0]    idx_dec;
    logic [KEY_W-1:0] req_biased;

    // Keys are stored with the sign bit flipped so that unsigned order is signed order.
    assign req_biased = req.req_key ^ SIGN_FLIP;
    assign idx_inc = idx_reg + CW'(1);
    assign idx_dec = idx_reg - CW'(1);

    // An insert reads two entries below the one it writes in the same cycle, so a read never meets a
    // pending write to the same entry.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        key_next     = key_reg;
        rank_next    = rank_reg;
        first_next   = first_reg;
        found_next   = found_reg;
        refused_next = refused_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = key_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    key_next     = req_biased;
                    rank_next    = '0;
                    first_next   = '0;
                    found_next   = 1'b0;
                    refused_next = 1'b0;
                    if (req.req_type == REQ_LOOKUP || count_reg == FULL_COUNT) begin
                        refused_next = (req.req_type == REQ_INSERT);
                        if (count_reg == '0) begin
                            state_next = ST_DONE;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            state_next = ST_UP;
                        end
                    end else if (count_reg == '0) begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = req_biased;
                        count_next = count_reg + CW'(1);
                        state_next = ST_DONE;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(count_reg - CW'(1));
                        idx_next   = count_reg - CW'(1);
                        state_next = ST_DOWN;
                    end
                end
            end
            ST_UP: begin
                if (rd_data < key_reg) begin
                    if (idx_inc == count_reg) begin
                        rank_next  = count_reg;
                        first_next = refused_reg ? '0 : count_reg;
                        state_next = ST_DONE;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(idx_inc);
                        idx_next = idx_inc;
                    end
                end else begin
                    rank_next = idx_reg;
                    if (!refused_reg) begin
                        found_next = (rd_data == key_reg);
                        first_next = (rd_data == key_reg) ? idx_reg : count_reg;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DOWN: begin
                wr_en   = 1'b1;
                wr_addr = AW'(idx_inc);
                if (rd_data >= key_reg) begin
                    wr_data = rd_data;
                    if (idx_reg == '0) begin
                        state_next = ST_PUT;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(idx_dec);
                        idx_next = idx_dec;
                    end
                end else begin
                    wr_data    = key_reg;
                    rank_next  = idx_inc;
                    count_next = count_reg + CW'(1);
                    state_next = ST_DONE;
                end
            end
            ST_PUT: begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = key_reg;
                rank_next  = '0;
                count_next = count_reg + CW'(1);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        key_reg     <= key_next;
        rank_reg    <= rank_next;
        first_reg   <= first_next;
        found_reg   <= found_next;
        refused_reg <= refused_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb begin
        res.key_found         = found_reg;
        res.rank_less         = FIELD_W'(rank_reg);
        res.first_match_index = FIELD_W'(first_reg);
        res.entry_count       = FIELD_W'(count_reg);
        res.insert_refused    = refused_reg;
    end

endmodule

// ===== rtl/skl_checker.sv =====
module skl_checker
    import skl_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input skl_req_t s_data,
    input logic     m_valid,
    input logic     m_ready,
    input skl_rsp_t m_data
);

    localparam bit NO_WRAP = (CAPACITY < 128);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("Request beat changed while stalled.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result beat changed while stalled.");

    a_refused_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.insert_refused |->
            !m_data.key_found && m_data.first_match_index == '0
            && (!NO_WRAP || 32'(m_data.entry_count) == CAPACITY))
        else $error("Refused insert with inconsistent fields.");

    a_found_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.key_found |->
            m_data.first_match_index == m_data.rank_less
            && (!NO_WRAP || m_data.rank_less < m_data.entry_count))
        else $error("Found key index disagrees with rank.");

    a_rank_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && NO_WRAP |->
            m_data.rank_less <= m_data.entry_count
            && 32'(m_data.entry_count) <= CAPACITY)
        else $error("Rank or entry count out of bounds.");

endmodule

bind sorted_key_list skl_checker #(
    .CAPACITY(CAPACITY)
) u_skl_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data(s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data(m_data)
);
